/* hw/rtl/ccs_pkg.sv */
package ccs_pkg;

  localparam int CODE_W  = 8;
  localparam int ENTRY_W = 16;
  localparam int PAIR_W  = 19;
  localparam int FC_W    = 4;
  localparam int ALPHA_W = 32;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam int PAIR_MAX = 262143;
  localparam int PAIR_MIN = -262144;

  localparam logic REG_FEATURE_COUNT = 1'b0;
  localparam logic REG_SIZE_FIELDS   = 1'b1;

  typedef logic [3:0] pc_t;

  localparam pc_t PC_IDLE     = 4'd0;
  localparam pc_t PC_WAIT_IN  = 4'd1;
  localparam pc_t PC_AX_INIT  = 4'd2;
  localparam pc_t PC_AX_LOOP  = 4'd3;
  localparam pc_t PC_SC_INIT  = 4'd4;
  localparam pc_t PC_SC_HI    = 4'd5;
  localparam pc_t PC_SC_LO    = 4'd6;
  localparam pc_t PC_SC_DRAIN = 4'd7;
  localparam pc_t PC_SC_EMIT  = 4'd8;
  localparam pc_t PC_SC_OOR   = 4'd9;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_CFG_DIRTY,
    C_SCORE_TAKEN,
    C_AX_LAST,
    C_OOR,
    C_CNT_ZERO,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    logic in_rdy;
    logic ax_init;
    logic ax_step;
    logic sc_init;
    logic div_hi;
    logic div_lo;
    logic emit;
    logic emit_oor;
  } op_t;

  typedef struct packed {
    op_t   op;
    cond_e cond;
    pc_t   jmp_to;
    pc_t   else_to;
  } ctl_t;

  typedef struct packed {
    logic               wr;
    logic [FC_W-1:0]    feature_count;
    logic [ALPHA_W-1:0] size_fields;
  } cfg_t;

  typedef struct packed {
    logic cfg_dirty;
    logic score_taken;
    logic ax_last;
    logic oor;
    logic cnt_zero;
    logic out_free;
  } stat_t;

  function automatic ctl_t ucode(input pc_t pc);
    ctl_t c;
    c = '0;
    c.cond    = C_ALWAYS;
    c.jmp_to  = PC_IDLE;
    c.else_to = PC_IDLE;
    unique case (pc)
      PC_IDLE: begin
        c.cond    = C_CFG_DIRTY;
        c.jmp_to  = PC_AX_INIT;
        c.else_to = PC_WAIT_IN;
      end
      PC_WAIT_IN: begin
        c.op.in_rdy = 1'b1;
        c.cond      = C_SCORE_TAKEN;
        c.jmp_to    = PC_SC_INIT;
        c.else_to   = PC_IDLE;
      end
      PC_AX_INIT: begin
        c.op.ax_init = 1'b1;
        c.jmp_to     = PC_AX_LOOP;
        c.else_to    = PC_AX_LOOP;
      end
      PC_AX_LOOP: begin
        c.op.ax_step = 1'b1;
        c.cond       = C_AX_LAST;
        c.jmp_to     = PC_IDLE;
        c.else_to    = PC_AX_LOOP;
      end
      PC_SC_INIT: begin
        c.op.sc_init = 1'b1;
        c.cond       = C_OOR;
        c.jmp_to     = PC_SC_OOR;
        c.else_to    = PC_SC_HI;
      end
      PC_SC_HI: begin
        c.op.div_hi = 1'b1;
        c.jmp_to    = PC_SC_LO;
        c.else_to   = PC_SC_LO;
      end
      PC_SC_LO: begin
        c.op.div_lo = 1'b1;
        c.cond      = C_CNT_ZERO;
        c.jmp_to    = PC_SC_DRAIN;
        c.else_to   = PC_SC_HI;
      end
      PC_SC_DRAIN: begin
        c.jmp_to  = PC_SC_EMIT;
        c.else_to = PC_SC_EMIT;
      end
      PC_SC_EMIT: begin
        c.op.emit = 1'b1;
        c.cond    = C_OUT_FREE;
        c.jmp_to  = PC_IDLE;
        c.else_to = PC_SC_EMIT;
      end
      PC_SC_OOR: begin
        c.op.emit_oor = 1'b1;
        c.cond        = C_OUT_FREE;
        c.jmp_to      = PC_IDLE;
        c.else_to     = PC_SC_OOR;
      end
      default: begin
        c.jmp_to  = PC_IDLE;
        c.else_to = PC_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/ccs_if.sv */
interface ccs_in_if import ccs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [2:0]                table_feature;
  logic [3:0]                table_row;
  logic [3:0]                table_col;
  logic signed [ENTRY_W-1:0] entry_value;
  logic [CODE_W-1:0]         first_code;
  logic [CODE_W-1:0]         second_code;

  modport source (
    output valid, kind, table_feature, table_row, table_col, entry_value,
           first_code, second_code,
    input  ready
  );

  modport sink (
    input  valid, kind, table_feature, table_row, table_col, entry_value,
           first_code, second_code,
    output ready
  );
endinterface

interface ccs_out_if import ccs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [PAIR_W-1:0] pair_score;
  logic                     code_out_of_range;

  modport source (
    output valid, pair_score, code_out_of_range,
    input  ready
  );

  modport sink (
    input  valid, pair_score, code_out_of_range,
    output ready
  );
endinterface

/* hw/rtl/ccs_apb.sv */
module ccs_apb import ccs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic               wr;
  logic [FC_W-1:0]    fc_q, fc_d;
  logic [ALPHA_W-1:0] alpha_q, alpha_d;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_comb begin
    fc_d    = fc_q;
    alpha_d = alpha_q;
    if (wr) begin
      unique case (paddr[2])
        REG_FEATURE_COUNT: fc_d    = pwdata[FC_W-1:0];
        REG_SIZE_FIELDS:   alpha_d = pwdata[ALPHA_W-1:0];
        default:           fc_d    = fc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q    <= FC_W'(1);
      alpha_q <= '0;
    end else begin
      fc_q    <= fc_d;
      alpha_q <= alpha_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FEATURE_COUNT: prdata = APB_DW'(fc_q);
      REG_SIZE_FIELDS:   prdata = APB_DW'(alpha_q);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.wr            = wr;
  assign cfg_o.feature_count = fc_q;
  assign cfg_o.size_fields   = alpha_q;

endmodule

/* hw/rtl/ccs_seq.sv */
module ccs_seq import ccs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output op_t   op_o
);

  pc_t  pc_q, pc_d;
  ctl_t cw;
  logic hit;

  assign cw   = ucode(pc_q);
  assign op_o = cw.op;

  always_comb begin
    unique case (cw.cond)
      C_ALWAYS:      hit = 1'b1;
      C_CFG_DIRTY:   hit = stat_i.cfg_dirty;
      C_SCORE_TAKEN: hit = stat_i.score_taken;
      C_AX_LAST:     hit = stat_i.ax_last;
      C_OOR:         hit = stat_i.oor;
      C_CNT_ZERO:    hit = stat_i.cnt_zero;
      C_OUT_FREE:    hit = stat_i.out_free;
      default:       hit = 1'b1;
    endcase
  end

  assign pc_d = hit ? cw.jmp_to : cw.else_to;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* hw/rtl/ccs_dp.sv */
module ccs_dp import ccs_pkg::*; #(
  parameter int MAX_FEATURES = 8,
  parameter int MAX_ALPHABET = 16,
  parameter int SCORE_BITS   = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ccs_in_if.sink   item_i,
  ccs_out_if.source score_o,
  input  cfg_t     cfg_i,
  input  op_t      op_i,
  output stat_t    stat_o
);

  localparam int FW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int DEPTH = MAX_FEATURES * MAX_ALPHABET * MAX_ALPHABET;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = SCORE_BITS + 4;
  localparam int XW    = (SW > PAIR_W) ? SW : PAIR_W;

  localparam logic signed [XW-1:0] SMAX = XW'(PAIR_MAX);
  localparam logic signed [XW-1:0] SMIN = XW'(PAIR_MIN);
  localparam logic signed [32:0]   E_HI = 33'((64'sd1 <<< (SCORE_BITS - 1)) - 64'sd1);
  localparam logic signed [32:0]   E_LO = -E_HI - 33'sd1;

  function automatic logic [8:0] div_bit(input logic [7:0] r, input logic [8:0] a,
                                         input logic [1:0] sh);
    logic [11:0] d;
    d = 12'(a) << sh;
    if ({4'b0, r} >= d) begin
      div_bit = {1'b1, 8'({4'b0, r} - d)};
    end else begin
      div_bit = {1'b0, r};
    end
  endfunction

  logic signed [SCORE_BITS-1:0] mem [DEPTH];
  logic signed [SCORE_BITS-1:0] rd_data_q;
  logic [8:0]                   axis_q [MAX_FEATURES];

  logic              cfg_dirty_q, cfg_dirty_d;
  logic [FW-1:0]     cnt_q, cnt_d;
  logic              rd_q;
  logic              out_valid_q, out_valid_d;
  logic [8:0]        prod_q;
  logic [7:0]        rem1_q, rem2_q;
  logic [1:0]        dig1_q, dig2_q;
  logic signed [SW-1:0]     sum_q;
  logic signed [PAIR_W-1:0] score_q;
  logic                     oor_q;

  logic              take, take_score, take_load, we, out_free, fire;
  logic [FW-1:0]     n_m1;
  logic [3:0]        fld [8];
  logic [4:0]        sz_raw, sz;
  logic [13:0]       pm;
  logic [8:0]        prod_next, ax;
  logic [8:0]        h1a, h1b, h2a, h2b, l1a, l1b, l2a, l2b;
  logic [3:0]        dig1, dig2;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic signed [32:0] ev;
  logic signed [SCORE_BITS-1:0] wdata;
  logic signed [XW-1:0]     sx;
  logic signed [PAIR_W-1:0] sat;

  assign item_i.ready = op_i.in_rdy & ~cfg_dirty_q;
  assign take         = item_i.valid & item_i.ready;
  assign take_score   = take & item_i.kind;
  assign take_load    = take & ~item_i.kind;

  always_comb begin
    if (cfg_i.feature_count == '0) begin
      n_m1 = '0;
    end else if (cfg_i.feature_count > FC_W'(MAX_FEATURES)) begin
      n_m1 = FW'(MAX_FEATURES - 1);
    end else begin
      n_m1 = FW'(cfg_i.feature_count - FC_W'(1));
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      fld[k] = cfg_i.size_fields[4*k +: 4];
    end
  end

  assign sz_raw    = {1'b0, fld[3'(cnt_q)]} + 5'd1;
  assign sz        = (sz_raw > 5'(MAX_ALPHABET)) ? 5'(MAX_ALPHABET) : sz_raw;
  assign pm        = 14'(prod_q) * 14'(sz);
  assign prod_next = (pm >= 14'd256) ? 9'd256 : pm[8:0];

  assign ax  = axis_q[cnt_q];
  assign h1a = div_bit(rem1_q, ax, 2'd3);
  assign h1b = div_bit(h1a[7:0], ax, 2'd2);
  assign h2a = div_bit(rem2_q, ax, 2'd3);
  assign h2b = div_bit(h2a[7:0], ax, 2'd2);
  assign l1a = div_bit(rem1_q, ax, 2'd1);
  assign l1b = div_bit(l1a[7:0], ax, 2'd0);
  assign l2a = div_bit(rem2_q, ax, 2'd1);
  assign l2b = div_bit(l2a[7:0], ax, 2'd0);
  assign dig1 = {dig1_q, l1a[8], l1b[8]};
  assign dig2 = {dig2_q, l2a[8], l2b[8]};

  assign rd_addr = (AW'(cnt_q) * AW'(MAX_ALPHABET) + AW'(dig1)) * AW'(MAX_ALPHABET)
                 + AW'(dig2);
  assign wr_addr = (AW'(item_i.table_feature) * AW'(MAX_ALPHABET) + AW'(item_i.table_row))
                 * AW'(MAX_ALPHABET) + AW'(item_i.table_col);

  assign we = take_load
            & ({1'b0, item_i.table_feature} < 4'(MAX_FEATURES))
            & ({1'b0, item_i.table_row} < 5'(MAX_ALPHABET))
            & ({1'b0, item_i.table_col} < 5'(MAX_ALPHABET));

  always_comb begin
    ev = 33'(item_i.entry_value);
    if (ev > E_HI) begin
      ev = E_HI;
    end else if (ev < E_LO) begin
      ev = E_LO;
    end
    wdata = ev[SCORE_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.div_lo) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign out_free = ~out_valid_q | score_o.ready;
  assign fire     = (op_i.emit | op_i.emit_oor) & out_free;

  always_comb begin
    cfg_dirty_d = cfg_dirty_q;
    if (cfg_i.wr) begin
      cfg_dirty_d = 1'b1;
    end else if (op_i.ax_init) begin
      cfg_dirty_d = 1'b0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (op_i.ax_init) begin
      cnt_d = '0;
    end else if (op_i.ax_step) begin
      cnt_d = cnt_q + FW'(1);
    end else if (op_i.sc_init) begin
      cnt_d = n_m1;
    end else if (op_i.div_lo) begin
      cnt_d = cnt_q - FW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (score_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_dirty_q <= 1'b1;
      cnt_q       <= '0;
      rd_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_dirty_q <= cfg_dirty_d;
      cnt_q       <= cnt_d;
      rd_q        <= op_i.div_lo;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.ax_init) begin
      prod_q <= 9'd1;
    end else if (op_i.ax_step) begin
      prod_q         <= prod_next;
      axis_q[cnt_q]  <= prod_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_score) begin
      rem1_q <= item_i.first_code;
      rem2_q <= item_i.second_code;
    end else if (op_i.div_hi) begin
      rem1_q <= h1b[7:0];
      rem2_q <= h2b[7:0];
      dig1_q <= {h1a[8], h1b[8]};
      dig2_q <= {h2a[8], h2b[8]};
    end else if (op_i.div_lo) begin
      rem1_q <= l1b[7:0];
      rem2_q <= l2b[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.sc_init) begin
      sum_q <= '0;
    end else if (rd_q) begin
      sum_q <= sum_q + SW'(rd_data_q);
    end
  end

  always_comb begin
    sx = XW'(sum_q);
    if (sx > SMAX) begin
      sat = PAIR_W'(SMAX);
    end else if (sx < SMIN) begin
      sat = PAIR_W'(SMIN);
    end else begin
      sat = sx[PAIR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      score_q <= op_i.emit_oor ? '0 : sat;
      oor_q   <= op_i.emit_oor;
    end
  end

  assign score_o.valid             = out_valid_q;
  assign score_o.pair_score        = score_q;
  assign score_o.code_out_of_range = oor_q;

  assign stat_o.cfg_dirty   = cfg_dirty_q;
  assign stat_o.score_taken = take_score;
  assign stat_o.ax_last     = (cnt_q == n_m1);
  assign stat_o.oor         = ({1'b0, rem1_q} >= prod_q) | ({1'b0, rem2_q} >= prod_q);
  assign stat_o.cnt_zero    = (cnt_q == '0);
  assign stat_o.out_free    = out_free;

endmodule

/* hw/rtl/compound_code_subst_scorer_top.sv */
// Channel   Direction  Handshake       Payload
// item_i    in         valid/ready     kind, table_feature, table_row, table_col,
//                                      entry_value, first_code, second_code
// score_o   out        valid/ready     pair_score, code_out_of_range
// apb       in/out     psel/penable    feature_count @0x0, alphabet_sizes_packed @0x4
//
// A load is taken in the input-wait step, which then returns to idle. A score runs
// an init step, then two quotient-bit steps per feature in use, the second one also
// reading the table, then drain and emit; a code out of range skips to an emit step.
// After reset and after every register write the sequencer rebuilds the per-feature
// axis values, an init step and then one step per feature, with item_i.ready held low;
// a write that lands during the rebuild makes it run again once it finishes.
// A finished score waits in the output register while the next transaction is taken;
// a new score stalls in its emit step only while that register is still full.
module compound_code_subst_scorer_top import ccs_pkg::*; #(
  parameter int MAX_FEATURES = 8,
  parameter int MAX_ALPHABET = 16,
  parameter int SCORE_BITS   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ccs_in_if.sink            item_i,
  ccs_out_if.source         score_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t  cfg;
  op_t   op;
  stat_t stat;

  ccs_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ccs_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .op_o   (op)
  );

  ccs_dp #(
    .MAX_FEATURES (MAX_FEATURES),
    .MAX_ALPHABET (MAX_ALPHABET),
    .SCORE_BITS   (SCORE_BITS)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .score_o (score_o),
    .cfg_i   (cfg),
    .op_i    (op),
    .stat_o  (stat)
  );

endmodule
